// ----- sv/pds_pkg.sv -----
// ----------------------------------------------------------------------------
// pds_pkg
// Shared types and constants of the PLL divider search block.
// ----------------------------------------------------------------------------
package pds_pkg;

    localparam int unsigned TGT_IN_W = 20;
    localparam int unsigned TGT_W    = 24;
    localparam int unsigned REF_W    = 16;
    localparam int unsigned CODE_W   = 3;
    localparam int unsigned MULT_W   = 4;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned ACH_W    = 26;
    localparam int unsigned TOL_W    = 14;
    localparam int unsigned APB_DW   = 32;
    localparam int unsigned APB_AW   = 3;

    localparam int unsigned REF_DIV_MIN = 2;
    localparam int unsigned VCO_DIV_MIN = 10;
    localparam int unsigned VCO_OFFSET  = 8;
    localparam int unsigned REF_OFFSET  = 2;

    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [TGT_IN_W-1:0] THR_LOW  = 20'd15000;
    localparam logic [TGT_IN_W-1:0] THR_MID  = 20'd30000;
    localparam logic [TGT_IN_W-1:0] THR_HIGH = 20'd60000;

    localparam logic [CODE_W-1:0] OD_CODE_LOW  = 3'd0;
    localparam logic [CODE_W-1:0] OD_CODE_MID  = 3'd4;
    localparam logic [CODE_W-1:0] OD_CODE_HIGH = 3'd6;
    localparam logic [CODE_W-1:0] OD_CODE_TOP  = 3'd1;

    localparam logic [MULT_W-1:0] MULT_LOW  = 4'd10;
    localparam logic [MULT_W-1:0] MULT_MID  = 4'd5;
    localparam logic [MULT_W-1:0] MULT_HIGH = 4'd3;
    localparam logic [MULT_W-1:0] MULT_TOP  = 4'd2;

    localparam logic [BYTE_W-1:0] MODE_BASE = 8'h10;
    localparam logic [BYTE_W-1:0] VLSB_FLAG = 8'h80;
    localparam logic [TOL_W-1:0]  TOL_KHZ   = 14'd10000;
    localparam logic [REF_W-1:0]  REF_RESET = 16'd20000;

    localparam logic REG_REF_IDX = 1'b0;

    typedef struct packed {
        logic [CODE_W-1:0] code;
        logic [TGT_W-1:0]  vco_target;
    } t_job;

endpackage

// ----- sv/pds_if.sv -----
// ----------------------------------------------------------------------------
// pds_if
// Valid/ready channels for target words and programming result words.
// ----------------------------------------------------------------------------
interface pds_in_if;
    logic                          valid;
    logic                          ready;
    logic [pds_pkg::TGT_IN_W-1:0]  target_khz;

    modport source (output valid, output target_khz, input ready);
    modport sink   (input valid, input target_khz, output ready);
endinterface

interface pds_out_if;
    logic                         valid;
    logic                         ready;
    logic [pds_pkg::BYTE_W-1:0]   mode_byte;
    logic [pds_pkg::BYTE_W-1:0]   vco_byte;
    logic [pds_pkg::BYTE_W-1:0]   ref_byte;
    logic                         found;
    logic [pds_pkg::ACH_W-1:0]    achieved_vco_khz;

    modport source (output valid, output mode_byte, output vco_byte, output ref_byte,
                    output found, output achieved_vco_khz, input ready);
    modport sink   (input valid, input mode_byte, input vco_byte, input ref_byte,
                    input found, input achieved_vco_khz, output ready);
endinterface

// ----- sv/pds_front.sv -----
// ----------------------------------------------------------------------------
// pds_front
// Holds the reference register and classifies each target into an output
// divider code and a VCO target.
// ----------------------------------------------------------------------------
module pds_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [pds_pkg::APB_AW-1:0]   paddr,
    input  logic [pds_pkg::APB_DW-1:0]   pwdata,
    output logic [pds_pkg::APB_DW-1:0]   prdata,
    output logic                         pready,
    input  logic                         i_valid,
    input  logic [pds_pkg::TGT_IN_W-1:0] i_target_khz,
    output logic                         o_ready,
    output logic                         o_push,
    output pds_pkg::t_job                o_job,
    input  logic                         i_push_ready,
    output logic [pds_pkg::REF_W-1:0]    o_ref
);

    logic [pds_pkg::REF_W-1:0]  r_ref;
    logic [pds_pkg::MULT_W-1:0] mult;
    logic                       reg_hit;

    assign reg_hit = (paddr[2] == pds_pkg::REG_REF_IDX);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref <= pds_pkg::REF_RESET;
        end else if (psel && penable && pwrite && reg_hit) begin
            r_ref <= pwdata[pds_pkg::REF_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = reg_hit ? pds_pkg::APB_DW'(r_ref) : '0;
    assign o_ref  = r_ref;

    always_comb begin
        o_job.code = pds_pkg::OD_CODE_LOW;
        mult       = pds_pkg::MULT_LOW;
        if (i_target_khz > pds_pkg::THR_HIGH) begin
            o_job.code = pds_pkg::OD_CODE_TOP;
            mult       = pds_pkg::MULT_TOP;
        end else if (i_target_khz > pds_pkg::THR_MID) begin
            o_job.code = pds_pkg::OD_CODE_HIGH;
            mult       = pds_pkg::MULT_HIGH;
        end else if (i_target_khz > pds_pkg::THR_LOW) begin
            o_job.code = pds_pkg::OD_CODE_MID;
            mult       = pds_pkg::MULT_MID;
        end
        o_job.vco_target = pds_pkg::TGT_W'(i_target_khz) * pds_pkg::TGT_W'(mult);
    end

    assign o_push  = i_valid;
    assign o_ready = i_push_ready;

endmodule

// ----- sv/pds_queue.sv -----
// ----------------------------------------------------------------------------
// pds_queue
// Short job queue between the classifier and the search engine.
// ----------------------------------------------------------------------------
module pds_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  pds_pkg::t_job i_job,
    output logic          o_push_ready,
    output logic          o_pop_valid,
    output pds_pkg::t_job o_job,
    input  logic          i_pop
);

    localparam int unsigned PTR_W = (pds_pkg::QUEUE_DEPTH > 1) ?
                                    $clog2(pds_pkg::QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(pds_pkg::QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(pds_pkg::QUEUE_DEPTH - 1);

    pds_pkg::t_job    r_mem [pds_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wp;
    logic [PTR_W-1:0] r_rp;
    logic [CNT_W-1:0] r_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_push_ready = (r_cnt != CNT_W'(pds_pkg::QUEUE_DEPTH));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_job        = r_mem[r_rp];
    assign do_push      = i_push && o_push_ready;
    assign do_pop       = i_pop && o_pop_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == LAST_PTR) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == LAST_PTR) ? '0 : r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ----- sv/pds_back.sv -----
// ----------------------------------------------------------------------------
// pds_back
// Walks every divider pair one per cycle, keeps the closest, then divides
// out the achieved VCO frequency and holds the result word.
// ----------------------------------------------------------------------------
module pds_back #(
    parameter int unsigned REF_DIV_MAX = 50,
    parameter int unsigned VCO_DIV_MAX = 511
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic [pds_pkg::REF_W-1:0]   i_ref,
    input  logic                        i_job_valid,
    input  pds_pkg::t_job               i_job,
    output logic                        o_job_pop,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [pds_pkg::BYTE_W-1:0]  o_mode_byte,
    output logic [pds_pkg::BYTE_W-1:0]  o_vco_byte,
    output logic [pds_pkg::BYTE_W-1:0]  o_ref_byte,
    output logic                        o_found,
    output logic [pds_pkg::ACH_W-1:0]   o_achieved_vco_khz
);

    localparam int unsigned R_W    = $clog2(REF_DIV_MAX + 1);
    localparam int unsigned V_W    = $clog2(VCO_DIV_MAX + 1);
    localparam int unsigned DEN_W  = $clog2(REF_DIV_MAX + pds_pkg::REF_OFFSET + 1);
    localparam int unsigned VP_W   = $clog2(VCO_DIV_MAX + pds_pkg::VCO_OFFSET + 1);
    localparam int unsigned PROD_W = pds_pkg::REF_W + VP_W;
    localparam int unsigned SC_W   = pds_pkg::TGT_W + DEN_W;
    localparam int unsigned NUM_W  = pds_pkg::TOL_W + DEN_W;
    localparam int unsigned CMP_W  = SC_W + DEN_W;
    localparam int unsigned DCNT_W = $clog2(PROD_W);

    localparam logic [R_W-1:0]    R_FIRST = R_W'(pds_pkg::REF_DIV_MIN);
    localparam logic [R_W-1:0]    R_LAST  = R_W'(REF_DIV_MAX);
    localparam logic [V_W-1:0]    V_FIRST = V_W'(pds_pkg::VCO_DIV_MIN);
    localparam logic [V_W-1:0]    V_LAST  = V_W'(VCO_DIV_MAX);
    localparam logic [DEN_W-1:0]  D_FIRST = DEN_W'(pds_pkg::REF_DIV_MIN + pds_pkg::REF_OFFSET);
    localparam logic [PROD_W-1:0] P_FIRST = PROD_W'(pds_pkg::VCO_DIV_MIN + pds_pkg::VCO_OFFSET);
    localparam logic [DCNT_W-1:0] DC_LAST = DCNT_W'(PROD_W - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_DRAIN,
        S_MUL,
        S_DIV,
        S_HOLD
    } t_state;

    t_state                     r_state;
    logic [pds_pkg::CODE_W-1:0] r_code;
    logic [pds_pkg::TGT_W-1:0]  r_tgt;
    logic [R_W-1:0]             r_r;
    logic [V_W-1:0]             r_v;
    logic [DEN_W-1:0]           r_den;
    logic [PROD_W-1:0]          r_prod;
    logic [SC_W-1:0]            r_scaled;

    logic                       r_a_vld;
    logic [SC_W-1:0]            r_a_err;
    logic [DEN_W-1:0]           r_a_den;
    logic [R_W-1:0]             r_a_r;
    logic [V_W-1:0]             r_a_v;

    logic                       r_hit;
    logic [NUM_W-1:0]           r_bnum;
    logic [DEN_W-1:0]           r_bden;
    logic [R_W-1:0]             r_br;
    logic [V_W-1:0]             r_bv;

    logic [PROD_W-1:0]          r_dvd;
    logic [DEN_W-1:0]           r_rem;
    logic [DCNT_W-1:0]          r_dcnt;

    logic                       r_ovld;
    logic [pds_pkg::BYTE_W-1:0] r_omode;
    logic [pds_pkg::BYTE_W-1:0] r_ovco;
    logic [pds_pkg::BYTE_W-1:0] r_oref;
    logic                       r_ofound;
    logic [pds_pkg::ACH_W-1:0]  r_oach;

    logic [SC_W-1:0]            prod_ext;
    logic [SC_W-1:0]            err;
    logic [CMP_W-1:0]           lhs;
    logic [CMP_W-1:0]           rhs;
    logic                       take;
    logic [DEN_W:0]             rem_sh;
    logic [DEN_W:0]             divisor;
    logic                       q_bit;
    logic [DEN_W:0]             rem_nx;
    logic [PROD_W-1:0]          prod_first;
    logic                       out_free;

    assign prod_first = PROD_W'(i_ref) * P_FIRST;
    assign prod_ext   = SC_W'(r_prod);
    assign err        = (prod_ext >= r_scaled) ? prod_ext - r_scaled : r_scaled - prod_ext;

    // err / den < best_num / best_den, cross-multiplied
    assign lhs  = CMP_W'(r_a_err) * CMP_W'(r_bden);
    assign rhs  = CMP_W'(r_bnum) * CMP_W'(r_a_den);
    assign take = r_a_vld && (lhs < rhs);

    assign rem_sh  = {r_rem, r_dvd[PROD_W-1]};
    assign divisor = (DEN_W + 1)'(r_br) + (DEN_W + 1)'(pds_pkg::REF_OFFSET);
    assign q_bit   = (rem_sh >= divisor);
    assign rem_nx  = q_bit ? rem_sh - divisor : rem_sh;

    assign out_free  = !r_ovld || i_ready;
    assign o_job_pop = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_a_vld <= 1'b0;
            r_ovld  <= 1'b0;
        end else begin
            r_a_vld <= 1'b0;
            if (r_ovld && i_ready) begin
                r_ovld <= 1'b0;
            end

            if (take) begin
                r_hit  <= 1'b1;
                r_bnum <= NUM_W'(r_a_err);
                r_bden <= r_a_den;
                r_br   <= r_a_r;
                r_bv   <= r_a_v;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_job_valid) begin
                        r_code   <= i_job.code;
                        r_tgt    <= i_job.vco_target;
                        r_r      <= R_FIRST;
                        r_v      <= V_FIRST;
                        r_den    <= D_FIRST;
                        r_prod   <= prod_first;
                        r_scaled <= SC_W'(i_job.vco_target) * SC_W'(D_FIRST);
                        r_hit    <= 1'b0;
                        r_bnum   <= NUM_W'(pds_pkg::TOL_KHZ);
                        r_bden   <= DEN_W'(1);
                        r_br     <= '0;
                        r_bv     <= '0;
                        r_state  <= S_SEARCH;
                    end
                end
                S_SEARCH: begin
                    r_a_vld <= 1'b1;
                    r_a_err <= err;
                    r_a_den <= r_den;
                    r_a_r   <= r_r;
                    r_a_v   <= r_v;
                    if (r_v == V_LAST) begin
                        if (r_r == R_LAST) begin
                            r_state <= S_DRAIN;
                        end else begin
                            r_r      <= r_r + 1'b1;
                            r_v      <= V_FIRST;
                            r_den    <= r_den + 1'b1;
                            r_prod   <= prod_first;
                            r_scaled <= r_scaled + SC_W'(r_tgt);
                        end
                    end else begin
                        r_v    <= r_v + 1'b1;
                        r_prod <= r_prod + PROD_W'(i_ref);
                    end
                end
                S_DRAIN: begin
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_dvd   <= PROD_W'(i_ref) * (PROD_W'(r_bv) + PROD_W'(pds_pkg::VCO_OFFSET));
                    r_rem   <= '0;
                    r_dcnt  <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_rem  <= rem_nx[DEN_W-1:0];
                    r_dvd  <= {r_dvd[PROD_W-2:0], q_bit};
                    r_dcnt <= r_dcnt + 1'b1;
                    if (r_dcnt == DC_LAST) begin
                        r_state <= S_HOLD;
                    end
                end
                S_HOLD: begin
                    if (out_free) begin
                        r_ovld <= 1'b1;
                        if (r_hit) begin
                            r_omode  <= pds_pkg::MODE_BASE | pds_pkg::BYTE_W'(r_code);
                            r_ovco   <= pds_pkg::BYTE_W'(r_bv >> 1);
                            r_oref   <= pds_pkg::BYTE_W'(r_br) |
                                        (r_bv[0] ? pds_pkg::VLSB_FLAG : '0);
                            r_ofound <= 1'b1;
                            r_oach   <= pds_pkg::ACH_W'(r_dvd);
                        end else begin
                            r_omode  <= '0;
                            r_ovco   <= '0;
                            r_oref   <= '0;
                            r_ofound <= 1'b0;
                            r_oach   <= '0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid            = r_ovld;
    assign o_mode_byte        = r_omode;
    assign o_vco_byte         = r_ovco;
    assign o_ref_byte         = r_oref;
    assign o_found            = r_ofound;
    assign o_achieved_vco_khz = r_oach;

endmodule

// ----- sv/pll_divider_search.sv -----
// sequence: an accepted target runs the search loop, then S_DRAIN, S_MUL and S_DIV,
//   and waits in S_HOLD until the result register is free
// rate: the search loop tries one divider pair per cycle, plus one quotient bit per
//   cycle in the final divide; one search runs at a time
// up to two further targets queue up while a search runs
// reset: synchronous active low, clears control state, reference reg to 20000 kHz
// ----------------------------------------------------------------------------
// pll_divider_search
// Top level: classifier front, job queue and divider search engine.
// ----------------------------------------------------------------------------
module pll_divider_search #(
    parameter int unsigned REF_DIV_MAX = 50,
    parameter int unsigned VCO_DIV_MAX = 511
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [pds_pkg::APB_AW-1:0] paddr,
    input  logic [pds_pkg::APB_DW-1:0] pwdata,
    output logic [pds_pkg::APB_DW-1:0] prdata,
    output logic                       pready,
    pds_in_if.sink                     i_tgt,
    pds_out_if.source                  o_res
);

    logic                      push;
    logic                      push_ready;
    pds_pkg::t_job             push_job;
    logic                      pop_valid;
    logic                      pop;
    pds_pkg::t_job             pop_job;
    logic [pds_pkg::REF_W-1:0] ref_khz;

    pds_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .i_valid      (i_tgt.valid),
        .i_target_khz (i_tgt.target_khz),
        .o_ready      (i_tgt.ready),
        .o_push       (push),
        .o_job        (push_job),
        .i_push_ready (push_ready),
        .o_ref        (ref_khz)
    );

    pds_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_job        (push_job),
        .o_push_ready (push_ready),
        .o_pop_valid  (pop_valid),
        .o_job        (pop_job),
        .i_pop        (pop)
    );

    pds_back #(
        .REF_DIV_MAX (REF_DIV_MAX),
        .VCO_DIV_MAX (VCO_DIV_MAX)
    ) u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_ref              (ref_khz),
        .i_job_valid        (pop_valid),
        .i_job              (pop_job),
        .o_job_pop          (pop),
        .o_valid            (o_res.valid),
        .i_ready            (o_res.ready),
        .o_mode_byte        (o_res.mode_byte),
        .o_vco_byte         (o_res.vco_byte),
        .o_ref_byte         (o_res.ref_byte),
        .o_found            (o_res.found),
        .o_achieved_vco_khz (o_res.achieved_vco_khz)
    );

endmodule

// ----- sv/pds_checker.sv -----
// ----------------------------------------------------------------------------
// pds_checker
// Port-level checks on the result channel of the divider search.
// ----------------------------------------------------------------------------
module pds_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_valid,
    input logic                       i_ready,
    input logic [pds_pkg::BYTE_W-1:0] i_mode_byte,
    input logic [pds_pkg::BYTE_W-1:0] i_vco_byte,
    input logic [pds_pkg::BYTE_W-1:0] i_ref_byte,
    input logic                       i_found,
    input logic [pds_pkg::ACH_W-1:0]  i_ach
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_mode_byte) && $stable(i_vco_byte)
            && $stable(i_ref_byte) && $stable(i_found) && $stable(i_ach))
        else $error("result word changed while stalled");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_found |-> i_mode_byte == '0 && i_vco_byte == '0
            && i_ref_byte == '0 && i_ach == '0)
        else $error("miss word carries non-zero fields");

    a_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_found |->
            i_mode_byte == (pds_pkg::MODE_BASE | 8'(pds_pkg::OD_CODE_LOW)) ||
            i_mode_byte == (pds_pkg::MODE_BASE | 8'(pds_pkg::OD_CODE_MID)) ||
            i_mode_byte == (pds_pkg::MODE_BASE | 8'(pds_pkg::OD_CODE_HIGH)) ||
            i_mode_byte == (pds_pkg::MODE_BASE | 8'(pds_pkg::OD_CODE_TOP)))
        else $error("illegal mode byte");

    a_ref_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_found |-> i_ref_byte[6:0] >= 7'(pds_pkg::REF_DIV_MIN))
        else $error("reference divider below minimum");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_valid)
        else $error("result valid straight after reset");

endmodule

bind pll_divider_search pds_checker u_pds_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (o_res.valid),
    .i_ready     (o_res.ready),
    .i_mode_byte (o_res.mode_byte),
    .i_vco_byte  (o_res.vco_byte),
    .i_ref_byte  (o_res.ref_byte),
    .i_found     (o_res.found),
    .i_ach       (o_res.achieved_vco_khz)
);
